@@ design/fpa_pkg.sv @@
// Package for the fixed-point ALU: operation codes, status codes, compare flag type.
// No dependencies.
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_CMP = 4'd4, OP_MIN = 4'd5, OP_MAX = 4'd6, OP_INC = 4'd7,
        OP_DEC = 4'd8, OP_TOINT = 4'd9, OP_FROMINT = 4'd10
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic is_less;
        logic is_equal;
        logic is_greater;
    } t_cmp;

endpackage

@@ design/fpa_if.sv @@
// Valid/ready channel interfaces for the fixed-point ALU.
// No dependencies.
interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic [1:0]         status;
    modport source (output valid, result_value, is_less, is_equal, is_greater, status,
                    input ready);
    modport sink   (input valid, result_value, is_less, is_equal, is_greater, status,
                    output ready);
endinterface

@@ design/fixed_point_alu_unit.sv @@
// Fixed-point ALU top level: pipelined add/sub/mul/div/compare unit.
// Depends on fpa_pkg and the interfaces in fpa_if.
// Registers from request transfer to result valid: stage 0 capture, setup stage, divider stages, output.
// Throughput: one transfer per cycle; a stall freezes the whole pipe in place.
// The divider is a restoring divider unrolled one quotient bit per stage,
// which sets the depth. Reset (synchronous, active low) clears valid bits only.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);
    import fpa_pkg::*;

    // Quotient of (|a|<<F)*2 + |b| over 2|b|: numerator below 2^(33+F+1).
    localparam int NW    = 34 + FRAC_BITS;   // numerator width
    localparam int DW    = 33;               // 2|b| width
    localparam int DEPTH = NW;               // one quotient bit per stage
    localparam int LAT   = DEPTH + 1;        // setup stage plus divider stages

    // stage 0 registers (operand capture)
    logic               r_v0;
    t_op                r_op0;
    logic signed [31:0] r_a0, r_b0;

    logic adv;
    logic [LAT-1:0] r_vs;     // valid per stage after stage 0
    assign adv = ~o_rsp.valid | o_rsp.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_req.valid;
        end
        if (adv) begin
            r_op0 <= t_op'(i_req.req_type);
            r_a0  <= i_req.operand_a;
            r_b0  <= i_req.operand_b;
        end
    end

    // stage 1: multiply, divider setup
    logic signed [63:0] n_prod;
    logic [NW-1:0]      n_num;
    logic [DW-1:0]      n_den;
    logic [31:0]        n_amag, n_bmag;
    assign n_prod = 64'(r_a0) * 64'(r_b0);
    assign n_amag = r_a0[31] ? 32'(-r_a0) : 32'(r_a0);
    assign n_bmag = r_b0[31] ? 32'(-r_b0) : 32'(r_b0);
    assign n_num  = (NW'(n_amag) << (FRAC_BITS + 1)) + NW'(n_bmag);
    assign n_den  = {n_bmag, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= '0;
        end else if (adv) begin
            r_vs <= {r_vs[LAT-2:0], r_v0};
        end
    end

    // divider stages: partial remainder, quotient, and item carried along;
    // entry 0 is the stage 1 setup, entry k+1 holds k+1 quotient bits
    logic [DW-1:0]      r_rem [DEPTH+1];
    logic [NW-1:0]      r_q   [DEPTH+1];
    logic [DW-1:0]      r_d   [DEPTH+1];
    logic signed [31:0] r_a   [DEPTH+1];
    logic signed [31:0] r_b   [DEPTH+1];
    t_op                r_op  [DEPTH+1];
    logic signed [63:0] r_p   [DEPTH+1];

    always_ff @(posedge i_clk) begin : p_div
        logic [DW:0] n_tr;
        logic [DW:0] n_sub;
        if (adv) begin
            r_rem[0] <= '0;
            r_q[0]   <= n_num;
            r_d[0]   <= n_den;
            r_a[0]   <= r_a0;
            r_b[0]   <= r_b0;
            r_op[0]  <= r_op0;
            r_p[0]   <= n_prod;
            for (int s = 0; s < DEPTH; s++) begin
                n_tr  = {r_rem[s], r_q[s][NW-1]};
                n_sub = n_tr - {1'b0, r_d[s]};
                r_rem[s+1] <= n_sub[DW] ? n_tr[DW-1:0] : n_sub[DW-1:0];
                r_q[s+1]   <= {r_q[s][NW-2:0], ~n_sub[DW]};
                r_d[s+1]   <= r_d[s];
                r_a[s+1]   <= r_a[s];
                r_b[s+1]   <= r_b[s];
                r_op[s+1]  <= r_op[s];
                r_p[s+1]   <= r_p[s];
            end
        end
    end

    // final stage: select, round multiply, saturate, divide-by-zero status
    logic signed [31:0] fa, fb;
    logic [NW-1:0]      fq;
    logic signed [63:0] fp;
    assign fa = r_a[DEPTH];
    assign fb = r_b[DEPTH];
    assign fq = r_q[DEPTH];
    assign fp = r_p[DEPTH];

    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    logic signed [63:0] n_wide, n_mq;
    logic [63:0]        n_pmag, n_rm;
    logic               n_sat;
    logic signed [31:0] n_res;
    logic [1:0]         n_st;

    always_comb begin
        n_pmag = fp[63] ? 64'(-fp) : 64'(fp);
        n_rm   = (n_pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_mq   = fp[63] ? -$signed(n_rm) : $signed(n_rm);
        n_wide = '0;
        n_sat  = 1'b1;
        n_st   = ST_OK;
        unique case (r_op[DEPTH])
            OP_ADD:     n_wide = 64'(fa) + 64'(fb);
            OP_SUB:     n_wide = 64'(fa) - 64'(fb);
            OP_MUL:     n_wide = n_mq;
            OP_DIV:     n_wide = (fa[31] ^ fb[31]) ? -$signed(64'(fq)) : $signed(64'(fq));
            OP_MIN:     n_wide = (fa > fb) ? 64'(fb) : 64'(fa);
            OP_MAX:     n_wide = (fa > fb) ? 64'(fa) : 64'(fb);
            OP_INC:     n_wide = 64'(fa) + 64'sd1;
            OP_DEC:     n_wide = 64'(fa) - 64'sd1;
            OP_TOINT:   n_wide = 64'(fa >>> FRAC_BITS);
            OP_FROMINT: n_wide = 64'(fa) <<< FRAC_BITS;
            default:    n_wide = '0;
        endcase
        if (n_wide > MAXV) begin
            n_res = 32'sh7fffffff;
        end else if (n_wide < MINV) begin
            n_res = 32'sh80000000;
        end else begin
            n_res = n_wide[31:0];
            n_sat = 1'b0;
        end
        if (n_sat) n_st = ST_OVF;
        if (r_op[DEPTH] == OP_DIV && fb == 32'sd0) begin
            n_st  = ST_DIV0;
            n_res = (fa > 0) ? 32'sh7fffffff : (fa < 0 ? 32'sh80000000 : 32'sd0);
        end
    end

    t_cmp n_cmp;
    assign n_cmp = '{is_less: fa < fb, is_equal: fa == fb, is_greater: fa > fb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp.valid <= 1'b0;
        end else if (adv) begin
            o_rsp.valid <= r_vs[LAT-1];
        end
        if (adv) begin
            o_rsp.result_value <= n_res;
            o_rsp.is_less      <= n_cmp.is_less;
            o_rsp.is_equal     <= n_cmp.is_equal;
            o_rsp.is_greater   <= n_cmp.is_greater;
            o_rsp.status       <= n_st;
        end
    end

endmodule
